@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SI_ASSERT_IMP(lbl, ante, cons)
`define SI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/si_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package si_pkg;
  localparam int OUT_BITS    = 26;
  localparam int SCALE       = 1000;
  localparam int ROUND_SCALE = 2000;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_AXIS,
    KIND_GEN
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;
endpackage
`default_nettype wire

@@ sv/si_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step: try to take D << SHIFT off the remainder.
module si_div_cell #(
  parameter int RW    = 65,
  parameter int DDW   = 36,
  parameter int QB    = 26,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [QB-1:0] q_i,
  input  logic [DDW-1:0] d_i,
  output logic [RW-1:0] rem_o,
  output logic [QB-1:0] q_o,
  output logic [DDW-1:0] d_o
);
  logic [RW-1:0]  dsh;
  logic [RW:0]    trial;
  logic           take;
  logic [RW-1:0]  rem_r;
  logic [QB-1:0]  q_r;
  logic [DDW-1:0] d_r;

  assign dsh   = RW'(d_i) << SHIFT;
  assign trial = {1'b0, rem_i} - {1'b0, dsh};
  assign take  = !trial[RW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= take ? trial[RW-1:0] : rem_i;
      q_r   <= {q_i[QB-2:0], take};
      d_r   <= d_i;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign d_o   = d_r;
endmodule
`default_nettype wire

@@ sv/si_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Early tests, line equations, rounding numerator and range check.
module si_front #(
  parameter  int CB  = 16,
  localparam int DW  = CB + 1,
  localparam int P1  = 2 * CB + 1,
  localparam int P2  = 2 * CB + 2,
  localparam int CW  = 2 * CB + 2,
  localparam int DETW = 2 * CB + 3,
  localparam int P3  = DW + CW,
  localparam int NXW = P3 + 1,
  localparam int NW  = NXW + 12,
  localparam int DDW = DETW + 1,
  localparam int LW  = CB + 11,
  localparam int MW  = LW + DDW,
  localparam int PW  = 3 * CB + 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [8*CB-1:0]      in_data,
  output si_pkg::ctl_t         ctl_o,
  output logic signed [LW-1:0] px_o,
  output logic signed [LW-1:0] py_o,
  output logic [PW-1:0]        rx_o,
  output logic [PW-1:0]        ry_o,
  output logic [DDW-1:0]       d_o
);
  logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [CB-1:0] mnx1, mxx1, mnx2, mxx2, mny1, mxy1, mny2, mxy2;
  logic signed [CB-1:0] lox, hix, loy, hiy, px_nxt, py_nxt;
  logic v1, h1, v2, h2, par, shr, dis;
  si_pkg::kind_t kind_nxt;

  assign x1 = in_data[0*CB +: CB];
  assign y1 = in_data[1*CB +: CB];
  assign x2 = in_data[2*CB +: CB];
  assign y2 = in_data[3*CB +: CB];
  assign x3 = in_data[4*CB +: CB];
  assign y3 = in_data[5*CB +: CB];
  assign x4 = in_data[6*CB +: CB];
  assign y4 = in_data[7*CB +: CB];

  assign mnx1 = (x1 < x2) ? x1 : x2;
  assign mxx1 = (x1 < x2) ? x2 : x1;
  assign mnx2 = (x3 < x4) ? x3 : x4;
  assign mxx2 = (x3 < x4) ? x4 : x3;
  assign mny1 = (y1 < y2) ? y1 : y2;
  assign mxy1 = (y1 < y2) ? y2 : y1;
  assign mny2 = (y3 < y4) ? y3 : y4;
  assign mxy2 = (y3 < y4) ? y4 : y3;
  assign lox  = (mnx1 > mnx2) ? mnx1 : mnx2;
  assign hix  = (mxx1 < mxx2) ? mxx1 : mxx2;
  assign loy  = (mny1 > mny2) ? mny1 : mny2;
  assign hiy  = (mxy1 < mxy2) ? mxy1 : mxy2;

  assign v1  = (x1 == x2);
  assign h1  = (y1 == y2);
  assign v2  = (x3 == x4);
  assign h2  = (y3 == y4);
  assign par = (v1 && v2) || (h1 && h2);
  assign shr = (x1 == x3 && y1 == y3) || (x2 == x4 && y2 == y4) ||
               (x1 == x4 && y1 == y4) || (x2 == x3 && y2 == y3);
  assign dis = (mxx1 < mnx2) || (mxx2 < mnx1) || (mxy1 < mny2) || (mxy2 < mny1);

  always_comb begin
    kind_nxt = si_pkg::KIND_GEN;
    px_nxt   = lox;
    py_nxt   = loy;
    if (par || shr || dis) begin
      kind_nxt = si_pkg::KIND_NONE;
    end else if (v1 && h2) begin
      kind_nxt = si_pkg::KIND_AXIS;
      px_nxt   = x1;
      py_nxt   = y3;
    end else if (h1 && v2) begin
      kind_nxt = si_pkg::KIND_AXIS;
      px_nxt   = x3;
      py_nxt   = y1;
    end
  end

  // control per stage
  si_pkg::ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r, s6_ctl_r, s7_ctl_r;
  si_pkg::ctl_t s5_ctl_nxt, o_ctl_nxt, o_ctl_r;

  // stage 1: differences and raw bounds
  logic signed [DW-1:0] s1_a1_r, s1_a2_r, s1_b1_r, s1_b2_r;
  logic signed [CB-1:0] s1_x1_r, s1_y1_r, s1_x3_r, s1_y3_r;
  logic signed [CB-1:0] s1_px_r, s1_py_r, s1_hx_r, s1_hy_r;
  // stage 2: first products, scaled bounds
  logic signed [P1-1:0] s2_a1x1_r, s2_b1y1_r, s2_a2x3_r, s2_b2y3_r;
  logic signed [P2-1:0] s2_a1b2_r, s2_a2b1_r;
  logic signed [DW-1:0] s2_a1_r, s2_a2_r, s2_b1_r, s2_b2_r;
  logic signed [LW-1:0] s2_px_r, s2_py_r, s2_hx_r, s2_hy_r;
  // stage 3: line constants and determinant
  logic signed [CW-1:0]   s3_c1_r, s3_c2_r;
  logic signed [DETW-1:0] s3_det_r;
  logic signed [DW-1:0]   s3_a1_r, s3_a2_r, s3_b1_r, s3_b2_r;
  logic signed [LW-1:0]   s3_px_r, s3_py_r, s3_hx_r, s3_hy_r;
  // stage 4: numerator products
  logic signed [P3-1:0]   s4_b2c1_r, s4_b1c2_r, s4_a1c2_r, s4_a2c1_r;
  logic signed [DETW-1:0] s4_det_r;
  logic signed [LW-1:0]   s4_px_r, s4_py_r, s4_hx_r, s4_hy_r;
  // stage 5: numerators with positive determinant
  logic signed [NXW-1:0]  s5_nx_r, s5_ny_r, nx_raw, ny_raw;
  logic signed [DETW-1:0] s5_dabs_r;
  logic signed [LW-1:0]   s5_px_r, s5_py_r, s5_hx_r, s5_hy_r;
  // stage 6: rounding numerator and divisor
  logic signed [NW-1:0]   s6_nx_r, s6_ny_r;
  logic signed [DDW-1:0]  s6_d_r;
  logic signed [LW-1:0]   s6_px_r, s6_py_r, s6_hx_r, s6_hy_r;
  // stage 7: bounds times divisor
  logic signed [MW-1:0]   s7_ldx_r, s7_hdx_r, s7_ldy_r, s7_hdy_r;
  logic signed [NW-1:0]   s7_nx_r, s7_ny_r;
  logic signed [DDW-1:0]  s7_d_r;
  logic signed [LW-1:0]   s7_px_r, s7_py_r;
  // output stage
  logic signed [PW-1:0]   rx_s, ry_s;
  logic                   okx, oky;
  logic [PW-1:0]          o_rx_r, o_ry_r;
  logic [DDW-1:0]         o_d_r;
  logic signed [LW-1:0]   o_px_r, o_py_r;

  assign nx_raw = NXW'(s4_b2c1_r) - NXW'(s4_b1c2_r);
  assign ny_raw = NXW'(s4_a1c2_r) - NXW'(s4_a2c1_r);

  always_comb begin
    s5_ctl_nxt = s4_ctl_r;
    if (s4_ctl_r.kind == si_pkg::KIND_GEN && s4_det_r == '0) begin
      s5_ctl_nxt.kind = si_pkg::KIND_NONE;
    end
  end

  assign rx_s = PW'(s7_nx_r) - PW'(s7_ldx_r);
  assign ry_s = PW'(s7_ny_r) - PW'(s7_ldy_r);
  assign okx  = (PW'(s7_nx_r) >= PW'(s7_ldx_r)) &&
                (PW'(s7_nx_r) - PW'(s7_hdx_r) < PW'(s7_d_r));
  assign oky  = (PW'(s7_ny_r) >= PW'(s7_ldy_r)) &&
                (PW'(s7_ny_r) - PW'(s7_hdy_r) < PW'(s7_d_r));

  always_comb begin
    o_ctl_nxt = s7_ctl_r;
    if (s7_ctl_r.kind == si_pkg::KIND_GEN && !(okx && oky)) begin
      o_ctl_nxt.kind = si_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
      s6_ctl_r <= '0;
      s7_ctl_r <= '0;
      o_ctl_r  <= '0;
    end else if (en) begin
      s1_ctl_r <= '{valid: in_valid, kind: kind_nxt};
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s5_ctl_nxt;
      s6_ctl_r <= s5_ctl_r;
      s7_ctl_r <= s6_ctl_r;
      o_ctl_r  <= o_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a1_r <= DW'(y2) - DW'(y1);
      s1_a2_r <= DW'(y4) - DW'(y3);
      s1_b1_r <= DW'(x1) - DW'(x2);
      s1_b2_r <= DW'(x3) - DW'(x4);
      s1_x1_r <= x1;
      s1_y1_r <= y1;
      s1_x3_r <= x3;
      s1_y3_r <= y3;
      s1_px_r <= px_nxt;
      s1_py_r <= py_nxt;
      s1_hx_r <= hix;
      s1_hy_r <= hiy;

      s2_a1x1_r <= P1'(s1_a1_r) * P1'(s1_x1_r);
      s2_b1y1_r <= P1'(s1_b1_r) * P1'(s1_y1_r);
      s2_a2x3_r <= P1'(s1_a2_r) * P1'(s1_x3_r);
      s2_b2y3_r <= P1'(s1_b2_r) * P1'(s1_y3_r);
      s2_a1b2_r <= P2'(s1_a1_r) * P2'(s1_b2_r);
      s2_a2b1_r <= P2'(s1_a2_r) * P2'(s1_b1_r);
      s2_a1_r   <= s1_a1_r;
      s2_a2_r   <= s1_a2_r;
      s2_b1_r   <= s1_b1_r;
      s2_b2_r   <= s1_b2_r;
      s2_px_r   <= LW'(s1_px_r) * LW'(si_pkg::SCALE);
      s2_py_r   <= LW'(s1_py_r) * LW'(si_pkg::SCALE);
      s2_hx_r   <= LW'(s1_hx_r) * LW'(si_pkg::SCALE);
      s2_hy_r   <= LW'(s1_hy_r) * LW'(si_pkg::SCALE);

      s3_c1_r  <= CW'(s2_a1x1_r) + CW'(s2_b1y1_r);
      s3_c2_r  <= CW'(s2_a2x3_r) + CW'(s2_b2y3_r);
      s3_det_r <= DETW'(s2_a1b2_r) - DETW'(s2_a2b1_r);
      s3_a1_r  <= s2_a1_r;
      s3_a2_r  <= s2_a2_r;
      s3_b1_r  <= s2_b1_r;
      s3_b2_r  <= s2_b2_r;
      s3_px_r  <= s2_px_r;
      s3_py_r  <= s2_py_r;
      s3_hx_r  <= s2_hx_r;
      s3_hy_r  <= s2_hy_r;

      s4_b2c1_r <= P3'(s3_b2_r) * P3'(s3_c1_r);
      s4_b1c2_r <= P3'(s3_b1_r) * P3'(s3_c2_r);
      s4_a1c2_r <= P3'(s3_a1_r) * P3'(s3_c2_r);
      s4_a2c1_r <= P3'(s3_a2_r) * P3'(s3_c1_r);
      s4_det_r  <= s3_det_r;
      s4_px_r   <= s3_px_r;
      s4_py_r   <= s3_py_r;
      s4_hx_r   <= s3_hx_r;
      s4_hy_r   <= s3_hy_r;

      // flip signs so the divisor is positive
      s5_nx_r   <= s4_det_r[DETW-1] ? -nx_raw : nx_raw;
      s5_ny_r   <= s4_det_r[DETW-1] ? -ny_raw : ny_raw;
      s5_dabs_r <= s4_det_r[DETW-1] ? -s4_det_r : s4_det_r;
      s5_px_r   <= s4_px_r;
      s5_py_r   <= s4_py_r;
      s5_hx_r   <= s4_hx_r;
      s5_hy_r   <= s4_hy_r;

      // floor((2000*n + det) / (2*det)) rounds half up
      s6_nx_r <= NW'(s5_nx_r) * NW'(si_pkg::ROUND_SCALE) + NW'(s5_dabs_r);
      s6_ny_r <= NW'(s5_ny_r) * NW'(si_pkg::ROUND_SCALE) + NW'(s5_dabs_r);
      s6_d_r  <= DDW'(s5_dabs_r) <<< 1;
      s6_px_r <= s5_px_r;
      s6_py_r <= s5_py_r;
      s6_hx_r <= s5_hx_r;
      s6_hy_r <= s5_hy_r;

      s7_ldx_r <= MW'(s6_px_r) * MW'(s6_d_r);
      s7_hdx_r <= MW'(s6_hx_r) * MW'(s6_d_r);
      s7_ldy_r <= MW'(s6_py_r) * MW'(s6_d_r);
      s7_hdy_r <= MW'(s6_hy_r) * MW'(s6_d_r);
      s7_nx_r  <= s6_nx_r;
      s7_ny_r  <= s6_ny_r;
      s7_d_r   <= s6_d_r;
      s7_px_r  <= s6_px_r;
      s7_py_r  <= s6_py_r;

      o_rx_r <= $unsigned(rx_s);
      o_ry_r <= $unsigned(ry_s);
      o_d_r  <= $unsigned(s7_d_r);
      o_px_r <= s7_px_r;
      o_py_r <= s7_py_r;
    end
  end

  assign ctl_o = o_ctl_r;
  assign px_o  = o_px_r;
  assign py_o  = o_py_r;
  assign rx_o  = o_rx_r;
  assign ry_o  = o_ry_r;
  assign d_o   = o_d_r;

  `SI_ASSERT_NXT(a_accept_enters, en && in_valid, s1_ctl_r.valid)
  `SI_ASSERT_IMP(a_div_nonzero, s6_ctl_r.valid && s6_ctl_r.kind == si_pkg::KIND_GEN, s6_d_r > 0)
  `SI_ASSERT_NXT(a_stall_holds, !en, $stable(o_ctl_r))
endmodule
`default_nettype wire

@@ sv/segment_intersection_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Channel  Dir  Bits        Contents
// in_      in   8*CB        segment pair, eight CB-bit signed coordinates
// out_     out  56          hit, crossing x and y in thousandths
//
// Cycles: one transaction per clock in and out when not stalled; the pipeline is
// eight stages of line algebra, one division cell per quotient bit and one
// output register. The CB + 10 quotient bits set the length of the cell row.
// Reset: clears valid flags along the whole pipeline; payload is not reset.
// Stalls: the whole pipeline holds while a result waits and out_tready is low.
module segment_intersection_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*COORD_BITS-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // hit [0], cross_x_milli [26:1], cross_y_milli [52:27], zero pad [55:53]
  output logic [55:0]             out_tdata
);
  localparam int CB   = COORD_BITS;
  localparam int DETW = 2 * CB + 3;
  localparam int DDW  = DETW + 1;
  localparam int LW   = CB + 11;
  localparam int PW   = 3 * CB + 17;
  localparam int QB   = CB + 10;
  localparam int OB   = si_pkg::OUT_BITS;
  localparam int SW   = (LW + 1 > OB) ? LW + 1 : OB;

  logic en;
  si_pkg::ctl_t         f_ctl;
  logic signed [LW-1:0] f_px, f_py;

  // division rows, index 0 is the front end
  logic [PW-1:0]  remx [QB+1];
  logic [PW-1:0]  remy [QB+1];
  logic [QB-1:0]  qx   [QB+1];
  logic [QB-1:0]  qy   [QB+1];
  logic [DDW-1:0] dx   [QB+1];
  logic [DDW-1:0] dy   [QB+1];

  // sideband line beside the cells
  si_pkg::ctl_t         ctl_sl_r [QB];
  logic signed [LW-1:0] px_sl_r  [QB];
  logic signed [LW-1:0] py_sl_r  [QB];

  logic signed [SW-1:0] ax, ay, gx, gy;
  logic                 hit_nxt;
  logic [OB-1:0]        cx_nxt, cy_nxt;
  logic                 out_valid_r;
  logic [55:0]          out_data_r;

  // advance unless a result sits unclaimed
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  si_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .ctl_o    (f_ctl),
    .px_o     (f_px),
    .py_o     (f_py),
    .rx_o     (remx[0]),
    .ry_o     (remy[0]),
    .d_o      (dx[0])
  );

  assign dy[0] = dx[0];
  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    si_div_cell #(.RW(PW), .DDW(DDW), .QB(QB), .SHIFT(QB - 1 - k)) u_cx (
      .clk (clk), .en (en),
      .rem_i (remx[k]), .q_i (qx[k]), .d_i (dx[k]),
      .rem_o (remx[k+1]), .q_o (qx[k+1]), .d_o (dx[k+1])
    );
    si_div_cell #(.RW(PW), .DDW(DDW), .QB(QB), .SHIFT(QB - 1 - k)) u_cy (
      .clk (clk), .en (en),
      .rem_i (remy[k]), .q_i (qy[k]), .d_i (dy[k]),
      .rem_o (remy[k+1]), .q_o (qy[k+1]), .d_o (dy[k+1])
    );
  end

  // advance the sideband in step with the cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QB; i++) ctl_sl_r[i] <= '0;
    end else if (en) begin
      ctl_sl_r[0] <= f_ctl;
      for (int i = 1; i < QB; i++) ctl_sl_r[i] <= ctl_sl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_sl_r[0] <= f_px;
      py_sl_r[0] <= f_py;
      for (int i = 1; i < QB; i++) begin
        px_sl_r[i] <= px_sl_r[i-1];
        py_sl_r[i] <= py_sl_r[i-1];
      end
    end
  end

  // axis case carries the point itself; general case adds quotient to low bound
  assign ax = SW'(px_sl_r[QB-1]);
  assign ay = SW'(py_sl_r[QB-1]);
  assign gx = ax + $signed(SW'({1'b0, qx[QB]}));
  assign gy = ay + $signed(SW'({1'b0, qy[QB]}));

  always_comb begin
    hit_nxt = 1'b0;
    cx_nxt  = '0;
    cy_nxt  = '0;
    case (ctl_sl_r[QB-1].kind)
      si_pkg::KIND_AXIS: begin
        hit_nxt = 1'b1;
        cx_nxt  = ax[OB-1:0];
        cy_nxt  = ay[OB-1:0];
      end
      si_pkg::KIND_GEN: begin
        hit_nxt = 1'b1;
        cx_nxt  = gx[OB-1:0];
        cy_nxt  = gy[OB-1:0];
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_sl_r[QB-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {3'b000, cy_nxt, cx_nxt, hit_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SI_ASSERT_IMP(a_nohit_zero, out_valid_r && !out_data_r[0], out_data_r[52:1] == '0)
  `SI_ASSERT_IMP(a_stall_cause, !in_tready, out_tvalid)
  `SI_ASSERT_NXT(a_row_end_lands, en && ctl_sl_r[QB-1].valid, out_tvalid)
endmodule
`default_nettype wire

@@ tb/segment_intersection_top_test.sv @@
`timescale 1ns / 1ps
module segment_intersection_top_test;
  localparam int CB = 16;
  localparam int LATENCY = 9 + CB + 10;

  typedef struct {
    logic signed [CB-1:0] c [8];
  } seg_pair_t;

  typedef struct {
    logic                 hit;
    logic [25:0]          xm;
    logic [25:0]          ym;
  } crossing_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [8*CB-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [55:0]          out_tdata;

  seg_pair_t  pair_queue [$];
  crossing_t  crossing_queue [$];
  int         mismatches = 0;
  int         idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
  int         hold_cycles = 0;   // long receiver hold-off
  bit         in_taken = 1'b0;   // input transaction accepted at the last rising edge

  segment_intersection_top #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Floor division of a signed numerator by a positive divisor.
  function automatic longint signed floor_div(longint signed n, longint signed d);
    longint signed q;
    q = n / d;
    if ((n % d != 0) && (n < 0)) q = q - 1;
    return q;
  endfunction

  // Predict the crossing of one segment pair.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint signed x1, y1, x2, y2, x3, y3, x4, y4;
    longint signed a1, a2, b1, b2, c1, c2, det, nx, ny, mx, my;
    longint signed lox, hix, loy, hiy;
    r.hit = 1'b0; r.xm = '0; r.ym = '0;
    x1 = p.c[0]; y1 = p.c[1]; x2 = p.c[2]; y2 = p.c[3];
    x3 = p.c[4]; y3 = p.c[5]; x4 = p.c[6]; y4 = p.c[7];
    if ((x1 == x2 && x3 == x4) || (y1 == y2 && y3 == y4)) return r;
    if ((x1 == x3 && y1 == y3) || (x2 == x4 && y2 == y4) ||
        (x1 == x4 && y1 == y4) || (x2 == x3 && y2 == y3)) return r;
    if ((x1 > x2 ? x1 : x2) < (x3 < x4 ? x3 : x4) ||
        (x3 > x4 ? x3 : x4) < (x1 < x2 ? x1 : x2) ||
        (y1 > y2 ? y1 : y2) < (y3 < y4 ? y3 : y4) ||
        (y3 > y4 ? y3 : y4) < (y1 < y2 ? y1 : y2)) return r;
    if (x1 == x2 && y3 == y4) begin
      r.hit = 1'b1; r.xm = 26'(x1 * 1000); r.ym = 26'(y3 * 1000);
      return r;
    end
    if (y1 == y2 && x3 == x4) begin
      r.hit = 1'b1; r.xm = 26'(x3 * 1000); r.ym = 26'(y1 * 1000);
      return r;
    end
    a1 = y2 - y1; a2 = y4 - y3; b1 = x1 - x2; b2 = x3 - x4;
    c1 = a1 * x1 + b1 * y1;
    c2 = a2 * x3 + b2 * y3;
    det = a1 * b2 - a2 * b1;
    if (det == 0) return r;
    // With 16-bit coordinates the numerators stay below 2^52, so 64 bits suffice.
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    if (det < 0) begin
      nx = -nx; ny = -ny; det = -det;
    end
    mx = floor_div(nx * 2000 + det, 2 * det);
    my = floor_div(ny * 2000 + det, 2 * det);
    lox = ((x1 < x2 ? x1 : x2) > (x3 < x4 ? x3 : x4) ? (x1 < x2 ? x1 : x2)
          : (x3 < x4 ? x3 : x4)) * 1000;
    hix = ((x1 > x2 ? x1 : x2) < (x3 > x4 ? x3 : x4) ? (x1 > x2 ? x1 : x2)
          : (x3 > x4 ? x3 : x4)) * 1000;
    loy = ((y1 < y2 ? y1 : y2) > (y3 < y4 ? y3 : y4) ? (y1 < y2 ? y1 : y2)
          : (y3 < y4 ? y3 : y4)) * 1000;
    hiy = ((y1 > y2 ? y1 : y2) < (y3 > y4 ? y3 : y4) ? (y1 > y2 ? y1 : y2)
          : (y3 > y4 ? y3 : y4)) * 1000;
    if (lox <= mx && mx <= hix && loy <= my && my <= hiy) begin
      r.hit = 1'b1; r.xm = 26'(mx); r.ym = 26'(my);
    end
    return r;
  endfunction

  function automatic seg_pair_t make_pair(int v0, int v1, int v2, int v3,
                                          int v4, int v5, int v6, int v7);
    seg_pair_t p;
    p.c[0] = CB'(v0); p.c[1] = CB'(v1); p.c[2] = CB'(v2); p.c[3] = CB'(v3);
    p.c[4] = CB'(v4); p.c[5] = CB'(v5); p.c[6] = CB'(v6); p.c[7] = CB'(v7);
    return p;
  endfunction

  function automatic logic signed [CB-1:0] rand_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'($urandom_range(2 * span) - span);
  endfunction

  // Random pair: mostly small crossing boxes so the general path is reached.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int kind, span, i;
    kind = $urandom_range(9);
    span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 20 : 2000);
    for (i = 0; i < 8; i++) p.c[i] = rand_coord(span);
    case (kind)
      0: begin p.c[2] = p.c[0]; p.c[5] = $urandom_range(1) ? p.c[7] : p.c[5];
         p.c[7] = p.c[5]; end
      1: begin p.c[3] = p.c[1]; p.c[6] = p.c[4]; end
      2: begin p.c[4] = p.c[2]; p.c[5] = p.c[3]; end
      3: begin p.c[2] = p.c[0]; p.c[6] = p.c[4]; end
      4: begin p.c[2] = p.c[0]; p.c[3] = p.c[1]; end
      default: begin
        // Cross one segment over the other by mirroring around a center.
        p.c[4] = p.c[0] + rand_coord(20); p.c[5] = p.c[3] + rand_coord(20);
        p.c[6] = p.c[2] + rand_coord(20); p.c[7] = p.c[1] + rand_coord(20);
      end
    endcase
    return p;
  endfunction

  // Capture input acceptance at the rising edge where it happens.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: offer the next pending pair; advance on each accepted transaction.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        crossing_queue.push_back(predict_crossing(pair_queue.pop_front()));
      end
      if (in_tvalid && !in_taken) begin
        // hold current transaction
      end else if (pair_queue.size() > 0 &&
                   !((idle_mode == 1 || idle_mode == 3) &&
                     $urandom_range(99) < (idle_mode == 1 ? 84 : 15))) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pair_queue[0].c[7], pair_queue[0].c[6], pair_queue[0].c[5],
                     pair_queue[0].c[4], pair_queue[0].c[3], pair_queue[0].c[2],
                     pair_queue[0].c[1], pair_queue[0].c[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if ((idle_mode == 2 || idle_mode == 3) &&
                   $urandom_range(99) < (idle_mode == 2 ? 84 : 15)) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    crossing_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (crossing_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = crossing_queue.pop_front();
        if (out_tdata[0] !== want.hit || out_tdata[26:1] !== want.xm ||
            out_tdata[52:27] !== want.ym || out_tdata[55:53] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit %0d x %h y %h, got hit %0d x %h y %h",
                     want.hit, want.xm, want.ym,
                     out_tdata[0], out_tdata[26:1], out_tdata[52:27]);
        end
      end
    end
  end

  // Pairs leave the queue only after acceptance, so wait for both queues.
  task automatic drain();
    while (pair_queue.size() > 0 || in_tvalid || crossing_queue.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int m, n;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes and each test path.
    pair_queue.push_back(make_pair(-32768, -32768, 32767, 32767,
                                   -32768, 32767, 32767, -32768));
    pair_queue.push_back(make_pair(32767, -32768, -32768, 32767,
                                   -32768, -32768, 32767, 32767));
    pair_queue.push_back(make_pair(0, -5, 0, 5, 3, -5, 3, 5));      // both vertical
    pair_queue.push_back(make_pair(-5, 1, 5, 1, -5, 2, 5, 2));      // both horizontal
    pair_queue.push_back(make_pair(0, 0, 4, 4, 0, 0, 4, -4));       // shared start
    pair_queue.push_back(make_pair(0, 0, 4, 4, 8, 0, 4, 4));        // shared end
    pair_queue.push_back(make_pair(0, 0, 4, 4, 4, 0, 0, 0));        // start1/end2
    pair_queue.push_back(make_pair(0, 0, 4, 4, 4, 4, 9, 0));        // end1/start2
    pair_queue.push_back(make_pair(0, 0, 1, 1, 5, 5, 6, 7));        // disjoint boxes
    pair_queue.push_back(make_pair(-32768, -32768, -32768, 32767,
                                   -32768, 32767, 32767, 32767));   // vertical/horizontal
    pair_queue.push_back(make_pair(3, -7, 3, 9, -2, 4, 8, 4));
    pair_queue.push_back(make_pair(-9, 2, 7, 2, 1, -3, 1, 6));      // horizontal/vertical
    pair_queue.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 2));       // general
    pair_queue.push_back(make_pair(0, 0, 3, 1, 1, 2, 2, -2));       // rounding
    pair_queue.push_back(make_pair(0, 0, 6, 6, 0, 1, 6, 7));        // parallel
    pair_queue.push_back(make_pair(2, 2, 2, 2, 0, 0, 4, 3));        // point segment
    pair_queue.push_back(make_pair(0, 0, 7, 3, -1, 5, 9, -4));
    pair_queue.push_back(make_pair(0, 0, 1, 0, 0, 1, 1, 5));        // lines miss boxes
    pair_queue.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pair_queue.push_back(make_pair(32767, 32767, -32768, -32768,
                                   32767, -32768, -32767, 32767));
    drain();

    // Random phases, one per idling mode.
    for (m = 0; m < 4; m++) begin
      idle_mode = m;
      for (n = 0; n < 280; n++) pair_queue.push_back(rand_pair());
      if (m == 0) begin
        // Long hold-off while the sender keeps offering.
        @(negedge clk) hold_cycles <= 200;
      end
      drain();
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && crossing_queue.size() == 0) begin
      $display("segment_intersection_top regression: pass");
    end else begin
      $display("segment_intersection_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("segment_intersection_top regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/si_pkg.sv
sv/si_div_cell.sv
sv/si_front.sv
sv/segment_intersection_top.sv
tb/segment_intersection_top_test.sv
